// ----- rtl/mqif_pkg.sv -----
// Shared constants for the monic quadratic integer factor block.
`default_nettype none

package mqif_pkg;

    // Default coefficient width (bits of b and c).
    localparam int COEF_WIDTH_DEF = 32;

    // Stages ahead of the square root: input capture, square, discriminant.
    localparam int FRONT_STAGES = 3;

    // Stages after the square root: root and flag output register.
    localparam int BACK_STAGES = 1;

endpackage : mqif_pkg

`default_nettype wire

// ----- rtl/monic_quadratic_integer_factor.sv -----
// Top level: pipelined integer factorization of x^2 + b*x + c.
`default_nettype none

//  channel  | direction | signals                                 | handshake
//  ---------+-----------+-----------------------------------------+-----------------------
//  command  | in        | i_lin_coeff, i_const_term               | start && !busy
//  result   | out       | o_factorable, o_root_hi, o_root_lo      | o_valid, one cycle
//
//  One transfer can be taken every cycle; busy never rises.
//  From an accepted start to o_valid an item passes the capture stage, the stage
//  for the square b*b, the discriminant subtract, the square root stages (each
//  settling one result bit with a 2*COEF_WIDTH-bit compare/subtract) and the
//  root and flag register.
//  i_rst_n (synchronous) clears every valid bit; data registers are not reset.
//  The receiver cannot stall, so the pipeline advances on every clock.

module monic_quadratic_integer_factor
    import mqif_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COEF_WIDTH-1:0] i_lin_coeff,
    input  wire logic signed [COEF_WIDTH-1:0] i_const_term,
    output logic                              o_valid,
    output logic                              o_factorable,
    output logic signed [COEF_WIDTH:0]        o_root_hi,
    output logic signed [COEF_WIDTH:0]        o_root_lo
);

    // Discriminant is below 2^(2W-1) and above -2^(W+1), so 2W signed bits hold it.
    localparam int DW      = 2 * COEF_WIDTH;
    localparam int NW      = COEF_WIDTH + 2;          // numerator width, -b +/- r
    localparam int LATENCY = FRONT_STAGES + COEF_WIDTH + BACK_STAGES;

    typedef logic [DW-1:0] t_wide;

    assign busy = 1'b0;

    wire logic w_take = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: capture coefficients, form |b|.
    // ------------------------------------------------------------------
    logic                         r_s1_vld;
    logic signed [COEF_WIDTH-1:0] r_s1_b;
    logic signed [COEF_WIDTH-1:0] r_s1_c;
    logic        [COEF_WIDTH-1:0] r_s1_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_take;
        end
        r_s1_b   <= i_lin_coeff;
        r_s1_c   <= i_const_term;
        r_s1_abs <= i_lin_coeff[COEF_WIDTH-1] ? COEF_WIDTH'(-i_lin_coeff)
                                              : COEF_WIDTH'(i_lin_coeff);
    end

    // ------------------------------------------------------------------
    // Stage 2: b*b (W x W unsigned) and 4*c sign extended.
    // ------------------------------------------------------------------
    logic                         r_s2_vld;
    logic signed [COEF_WIDTH-1:0] r_s2_b;
    t_wide                        r_s2_sq;
    t_wide                        r_s2_c4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_b  <= r_s1_b;
        r_s2_sq <= r_s1_abs * r_s1_abs;
        r_s2_c4 <= {{(COEF_WIDTH-2){r_s1_c[COEF_WIDTH-1]}}, r_s1_c, 2'b00};
    end

    // ------------------------------------------------------------------
    // Stage 3: discriminant. A negative one enters the root pipe as zero.
    // ------------------------------------------------------------------
    t_wide w_disc;
    assign w_disc = r_s2_sq - r_s2_c4;

    // Square root pipe: index 0 is its input, index COEF_WIDTH its output.
    logic                         r_rt_vld [COEF_WIDTH+1];
    logic                         r_rt_neg [COEF_WIDTH+1];
    logic signed [COEF_WIDTH-1:0] r_rt_b   [COEF_WIDTH+1];
    t_wide                        r_rt_x   [COEF_WIDTH+1];
    t_wide                        r_rt_res [COEF_WIDTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld[0] <= 1'b0;
        end else begin
            r_rt_vld[0] <= r_s2_vld;
        end
        r_rt_neg[0] <= w_disc[DW-1];
        r_rt_b[0]   <= r_s2_b;
        r_rt_x[0]   <= w_disc[DW-1] ? '0 : w_disc;
        r_rt_res[0] <= '0;
    end

    // ------------------------------------------------------------------
    // Stages 4 .. 3+W: one result bit of the digit-by-digit root per stage.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < COEF_WIDTH; k++) begin : g_root
        localparam t_wide BIT = t_wide'(1) << (2 * (COEF_WIDTH - 1 - k));

        t_wide n_try;
        t_wide n_x;
        t_wide n_res;

        always_comb begin
            n_try = r_rt_res[k] + BIT;
            if (r_rt_x[k] >= n_try) begin
                n_x   = r_rt_x[k] - n_try;
                n_res = (r_rt_res[k] >> 1) + BIT;
            end else begin
                n_x   = r_rt_x[k];
                n_res = r_rt_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[k+1] <= 1'b0;
            end else begin
                r_rt_vld[k+1] <= r_rt_vld[k];
            end
            r_rt_neg[k+1] <= r_rt_neg[k];
            r_rt_b[k+1]   <= r_rt_b[k];
            r_rt_x[k+1]   <= n_x;
            r_rt_res[k+1] <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // Final stage: exactness (zero remainder), parity, halved numerators.
    // ------------------------------------------------------------------
    logic signed [NW-1:0] n_b_ext;
    logic signed [NW-1:0] n_r_ext;
    logic signed [NW-1:0] n_num_hi;
    logic signed [NW-1:0] n_num_lo;
    logic                 n_ok;

    always_comb begin
        n_b_ext  = {{2{r_rt_b[COEF_WIDTH][COEF_WIDTH-1]}}, r_rt_b[COEF_WIDTH]};
        n_r_ext  = {1'b0, r_rt_res[COEF_WIDTH][COEF_WIDTH:0]};
        n_num_hi = n_r_ext - n_b_ext;
        n_num_lo = -n_r_ext - n_b_ext;
        n_ok     = !r_rt_neg[COEF_WIDTH] && (r_rt_x[COEF_WIDTH] == '0)
                   && !n_num_hi[0] && !n_num_lo[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_rt_vld[COEF_WIDTH];
        end
        o_factorable <= n_ok;
        o_root_hi    <= n_ok ? n_num_hi[NW-1:1] : '0;
        o_root_lo    <= n_ok ? n_num_lo[NW-1:1] : '0;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_valid)
        else $error("accepted command did not yield a result at fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_rt_vld[COEF_WIDTH]))
        else $error("result strobe without an item in the last root stage");

    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_factorable |-> (o_root_hi == '0) && (o_root_lo == '0))
        else $error("roots not zero for a non-factorable result");

    a_root_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_factorable |-> (o_root_hi >= o_root_lo))
        else $error("upper root below lower root");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule : monic_quadratic_integer_factor

`default_nettype wire
